[sv/text_console_writer_defines.svh]
// assertion macros for the text console writer
// depends on nothing; included by modules that carry assertions
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("tcw: implication check failed");
`define TCW_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("tcw: next-cycle check failed");
`else
`define TCW_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define TCW_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

[sv/tcw_pkg.sv]
// shared types and constants of the text console writer
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

  typedef logic [15:0] cell_t;

  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_SET   = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_FILL   = 5'b01000,
    S_SCROLL = 5'b10000
  } state_t;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  localparam int unsigned CFG_ADDR_W  = 3;
  localparam logic        REG_ATTRIBUTE = 1'b0;

endpackage

[sv/tcw_cell_ram.sv]
// single-port-write, single-port-read cell memory, registered read data
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tcw_pkg::cell_t  wdata,
  input  logic [AW-1:0]   raddr,
  output tcw_pkg::cell_t  rdata
);
  import tcw_pkg::*;

  cell_t mem [DEPTH];
  cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/tcw_seq.sv]
// command sequencer: cursor, put/clear/set/read, scroll and fill sweeps
// depends on tcw_pkg and text_console_writer_defines.svh; drives tcw_cell_ram
`timescale 1ns / 1ps

`include "text_console_writer_defines.svh"

module tcw_seq #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  tcw_pkg::func_t  func,
  input  logic [7:0]      char_code,
  input  logic [7:0]      column,
  input  logic [7:0]      row,
  input  logic [10:0]     cell_index,
  input  logic [7:0]      attr,
  output logic            out_valid,
  output logic [10:0]     out_cursor_position,
  output logic [15:0]     out_cell_value,
  output logic            out_scrolled,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output tcw_pkg::cell_t  mem_wdata,
  output logic [AW-1:0]   mem_raddr,
  input  tcw_pkg::cell_t  mem_rdata
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int NMOVE = (ROWS - 1) * COLUMNS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int PW    = (AW > 11) ? AW : 11;
  localparam int CNTW  = $clog2(CELLS + 1);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic            out_valid_r, out_valid_nxt;
  cell_t           out_cell_r, out_cell_nxt;
  logic            out_scr_r, out_scr_nxt;

  logic [PW-1:0]   lin;
  logic [PW-1:0]   idx_ext;
  logic            idx_ok;
  logic [CNTW-1:0] cnt_m1;
  logic [CNTW-1:0] rd_sw;
  cell_t           blank;
  logic            col_last, row_last, is_nl, put_wrap, put_scroll;

  assign lin      = PW'(row_r) * PW'(COLUMNS) + PW'(col_r);
  assign idx_ext  = PW'(cell_index);
  assign idx_ok   = {1'b0, idx_ext} < (PW+1)'(CELLS);
  assign cnt_m1   = cnt_r - CNTW'(1);
  assign rd_sw    = cnt_r + CNTW'(COLUMNS);
  assign blank    = {attr, SPACE_CODE};
  assign col_last = (col_r == CW'(COLUMNS - 1));
  assign row_last = (row_r == RW'(ROWS - 1));
  assign is_nl    = (char_code == NEWLINE_CODE);
  assign put_wrap   = is_nl || col_last;
  assign put_scroll = put_wrap && row_last;

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cnt_nxt       = cnt_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_cell_nxt  = out_cell_r;
    out_scr_nxt   = out_scr_r;
    mem_we        = 1'b0;
    mem_waddr     = lin[AW-1:0];
    mem_wdata     = {attr, char_code};
    mem_raddr     = idx_ext[AW-1:0];
    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = {ATTR_RESET, SPACE_CODE};
        if (cnt_r == CNTW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          case (func)
            FUNC_PUT: begin
              mem_we = !is_nl;
              if (put_wrap) begin
                col_nxt = '0;
                row_nxt = row_last ? row_r : row_r + RW'(1);
              end else begin
                col_nxt = col_r + CW'(1);
              end
              if (put_scroll) begin
                state_nxt = S_SCROLL;
                cnt_nxt   = '0;
              end else begin
                out_valid_nxt = 1'b1;
                out_cell_nxt  = '0;
                out_scr_nxt   = 1'b0;
              end
            end
            FUNC_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              state_nxt = S_FILL;
              cnt_nxt   = '0;
            end
            FUNC_SET: begin
              col_nxt = (column < 8'(COLUMNS)) ? column[CW-1:0] : CW'(COLUMNS - 1);
              row_nxt = (row < 8'(ROWS)) ? row[RW-1:0] : RW'(ROWS - 1);
              out_valid_nxt = 1'b1;
              out_cell_nxt  = '0;
              out_scr_nxt   = 1'b0;
            end
            FUNC_READ: begin
              rd_ok_nxt = idx_ok;
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_cell_nxt  = rd_ok_r ? mem_rdata : '0;
        out_scr_nxt   = 1'b0;
        state_nxt     = S_IDLE;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = blank;
        if (cnt_r == CNTW'(CELLS - 1)) begin
          state_nxt     = S_IDLE;
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_cell_nxt  = '0;
          out_scr_nxt   = 1'b0;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      S_SCROLL: begin
        // read one row below, write it back in the next cycle
        mem_raddr = (cnt_r < CNTW'(NMOVE)) ? rd_sw[AW-1:0] : '0;
        mem_we    = (cnt_r != '0);
        mem_waddr = cnt_m1[AW-1:0];
        mem_wdata = (cnt_m1 < CNTW'(NMOVE)) ? mem_rdata : blank;
        if (cnt_r == CNTW'(CELLS)) begin
          state_nxt     = S_IDLE;
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_cell_nxt  = '0;
          out_scr_nxt   = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_scr_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cnt_r       <= cnt_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
      out_scr_r   <= out_scr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cell_r <= out_cell_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_cursor_position = lin[10:0];
  assign out_cell_value      = out_cell_r;
  assign out_scrolled        = out_scr_r;

  `TCW_ASSERT_IMP(a_no_result_in_sweep, clk, rst_n,
    ((state_r == S_INIT) || (state_r == S_FILL) || (state_r == S_SCROLL)), (!out_valid_r))
  `TCW_ASSERT_NXT(a_put_result_next, clk, rst_n,
    (start && !busy && (func == FUNC_PUT) && !put_scroll), (out_valid_r && !out_scr_r))
  `TCW_ASSERT_IMP(a_cursor_in_grid, clk, rst_n, (1'b1),
    (({1'b0, col_r} < (CW+1)'(COLUMNS)) && ({1'b0, row_r} < (RW+1)'(ROWS))))
  `TCW_ASSERT_IMP(a_write_in_range, clk, rst_n, (mem_we),
    ({1'b0, mem_waddr} < (AW+1)'(CELLS)))

endmodule

[sv/text_console_writer.sv]
// Text console writer. A put-char that does not scroll and a set-cursor
// keep busy low, and the result strobes out_valid in the cycle after start.
// A read-cell goes through the S_READ state for the registered memory read.
// Clear walks the cell memory one write per cycle. A put that runs past the
// last row scrolls by copying every cell one row up through the single read
// and write port, blanking the bottom row on the way. After reset the block
// runs a clearing pass with busy high; configuration writes are taken
// throughout. Each result is on the out_ ports for exactly one cycle and
// cannot be stalled.
// top level: APB attribute register, tcw_seq and tcw_cell_ram; uses tcw_pkg
`timescale 1ns / 1ps

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_func,
  input  logic [7:0]                     in_char_code,
  input  logic [7:0]                     in_column,
  input  logic [7:0]                     in_row,
  input  logic [10:0]                    in_cell_index,
  output logic                           out_valid,
  output logic [10:0]                    out_cursor_position,
  output logic [15:0]                    out_cell_value,
  output logic                           out_scrolled,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic [7:0]    attr_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  cell_t         mem_wdata;
  cell_t         mem_rdata;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_ATTRIBUTE);
  assign prdata  = reg_sel ? {24'd0, attr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      attr_r <= pwdata[7:0];
    end
  end

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .func                (func_t'(in_func)),
    .char_code           (in_char_code),
    .column              (in_column),
    .row                 (in_row),
    .cell_index          (in_cell_index),
    .attr                (attr_r),
    .out_valid           (out_valid),
    .out_cursor_position (out_cursor_position),
    .out_cell_value      (out_cell_value),
    .out_scrolled        (out_scrolled),
    .mem_we              (mem_we),
    .mem_waddr           (mem_waddr),
    .mem_wdata           (mem_wdata),
    .mem_raddr           (mem_raddr),
    .mem_rdata           (mem_rdata)
  );

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[tb/text_console_writer_tb.sv]
// self-checking testbench for the text console writer: command requests,
// attribute register over the APB port, a shadow grid that predicts every result
// depends on tcw_pkg and text_console_writer
`timescale 1ns / 1ps

module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int CELLS          = ROWS * COLUMNS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 255;
  localparam logic [CFG_ADDR_W-1:0] ATTR_ADDR = {REG_ATTRIBUTE, 2'b00};

  typedef struct {
    func_t       func;
    logic [7:0]  ch;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [10:0] idx;
  } console_req_t;

  typedef struct {
    logic [10:0] pos;
    cell_t       cell_value;
    logic        scrolled;
  } console_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [7:0] in_char_code = '0;
  logic [7:0] in_column = '0;
  logic [7:0] in_row = '0;
  logic [10:0] in_cell_index = '0;
  logic out_valid;
  logic [10:0] out_cursor_position;
  logic [15:0] out_cell_value;
  logic out_scrolled;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_char_code(in_char_code), .in_column(in_column),
    .in_row(in_row), .in_cell_index(in_cell_index),
    .out_valid(out_valid), .out_cursor_position(out_cursor_position),
    .out_cell_value(out_cell_value), .out_scrolled(out_scrolled),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the console state
  cell_t      shadow_cells [CELLS];
  logic [6:0] shadow_col;
  logic [4:0] shadow_row;
  logic [7:0] shadow_attr;

  console_req_t    cmd_backlog[$];
  console_result_t results_due[$];
  console_req_t    cur_cmd = '{FUNC_PUT, 8'h00, 8'h00, 8'h00, 11'h000};

  int  mismatches = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_puts = 0;
  int  n_scrolls = 0;
  int  n_clears = 0;
  int  n_sets = 0;
  int  n_reads = 0;
  int  n_attr_writes = 0;
  int  quiet_cycles = 0;
  int  gap = 0;
  bit  idle_en = 1'b1;
  bit  go;
  logic next_start;
  console_result_t got;
  console_result_t exp_res;

  task automatic flag_mismatch(input string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic void blank_grid();
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_attr, SPACE_CODE};
  endfunction

  function automatic console_result_t step_console(console_req_t c);
    console_result_t r;
    r.cell_value = '0;
    r.scrolled   = 1'b0;
    case (c.func)
      FUNC_PUT: begin
        if (c.ch == NEWLINE_CODE) begin
          shadow_col = '0;
          shadow_row = shadow_row + 1'b1;
        end else begin
          shadow_cells[int'(shadow_row) * COLUMNS + int'(shadow_col)] = {shadow_attr, c.ch};
          shadow_col = shadow_col + 1'b1;
        end
        if (shadow_col >= COLUMNS) begin
          shadow_col = '0;
          shadow_row = shadow_row + 1'b1;
        end
        if (shadow_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++)
            shadow_cells[i] = {shadow_attr, SPACE_CODE};
          shadow_row = 5'(ROWS - 1);
          r.scrolled = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        blank_grid();
        shadow_col = '0;
        shadow_row = '0;
      end
      FUNC_SET: begin
        shadow_col = (c.col < COLUMNS) ? c.col[6:0] : 7'(COLUMNS - 1);
        shadow_row = (c.row < ROWS) ? c.row[4:0] : 5'(ROWS - 1);
      end
      default: begin
        if (c.idx < CELLS) r.cell_value = shadow_cells[c.idx];
      end
    endcase
    r.pos = 11'(int'(shadow_row) * COLUMNS + int'(shadow_col));
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap = 0;
    end else begin
      next_start = start;
      go = 1'b0;
      if (start && !busy) begin
        got = step_console(cur_cmd);
        results_due.push_back(got);
        n_accepted++;
        case (cur_cmd.func)
          FUNC_PUT:   n_puts++;
          FUNC_CLEAR: n_clears++;
          FUNC_SET:   n_sets++;
          default:    n_reads++;
        endcase
        if (got.scrolled) n_scrolls++;
        next_start = 1'b0;
        if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
        else go = 1'b1;
      end else if (!start) begin
        if (gap > 0) gap = gap - 1;
        go = (gap == 0);
      end
      if (go && cmd_backlog.size() > 0) begin
        cur_cmd = cmd_backlog.pop_front();
        next_start = 1'b1;
      end
      start         <= next_start;
      in_func       <= cur_cmd.func;
      in_char_code  <= cur_cmd.ch;
      in_column     <= cur_cmd.col;
      in_row        <= cur_cmd.row;
      in_cell_index <= cur_cmd.idx;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: pos %0d cell %h scrolled %0b",
                                out_cursor_position, out_cell_value, out_scrolled));
      end else begin
        exp_res = results_due.pop_front();
        n_checked++;
        if (out_cursor_position !== exp_res.pos || out_cell_value !== exp_res.cell_value ||
            out_scrolled !== exp_res.scrolled)
          flag_mismatch($sformatf(
            "result %0d: pos exp %0d got %0d, cell exp %h got %h, scrolled exp %0b got %0b",
            n_checked, exp_res.pos, out_cursor_position, exp_res.cell_value, out_cell_value,
            exp_res.scrolled, out_scrolled));
      end
    end
  end

  // watchdog on cycles without any request, result or register access
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results pending",
               quiet_cycles, results_due.size());
      $display("text_console_writer_tb NOT OK");
      $finish;
    end
  end

  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_attr();
    logic [31:0] rd;
    cfg_access(1'b0, ATTR_ADDR, 32'h0, rd);
    if (rd[7:0] !== shadow_attr)
      flag_mismatch($sformatf("attribute readback exp %h got %h", shadow_attr, rd[7:0]));
  endtask

  task automatic set_attr(input logic [7:0] value);
    logic [31:0] rd;
    cfg_access(1'b1, ATTR_ADDR, {24'($urandom_range(0, 32'hFFFFFF)), value}, rd);
    shadow_attr = value;
    n_attr_writes++;
    check_attr();
  endtask

  task automatic queue_cmd(input func_t f, input logic [7:0] ch, input logic [7:0] col,
                           input logic [7:0] row, input logic [10:0] idx);
    console_req_t c;
    c.func = f;
    c.ch   = ch;
    c.col  = col;
    c.row  = row;
    c.idx  = idx;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_random_cmds(input int n);
    console_req_t c;
    int r;
    for (int k = 0; k < n; k++) begin
      c.ch  = 8'($urandom_range(0, 255));
      c.col = 8'($urandom_range(0, 255));
      c.row = 8'($urandom_range(0, 255));
      c.idx = 11'($urandom_range(0, 2047));
      r = $urandom_range(0, 99);
      if (r < 55) begin
        c.func = FUNC_PUT;
        if ($urandom_range(0, 9) == 0) c.ch = NEWLINE_CODE;
      end else if (r < 70) begin
        c.func = FUNC_SET;
        if ($urandom_range(0, 4) != 0) c.col = 8'($urandom_range(0, COLUMNS - 1));
        case ($urandom_range(0, 9))
          0, 1, 2:    ;
          3, 4, 5, 6: c.row = 8'(ROWS - 1);
          default:    c.row = 8'($urandom_range(0, ROWS - 1));
        endcase
      end else if (r < 99) begin
        c.func = FUNC_READ;
        if ($urandom_range(0, 7) != 0) c.idx = 11'($urandom_range(0, CELLS - 1));
        else c.idx = 11'($urandom_range(CELLS, 2047));
      end else begin
        c.func = FUNC_CLEAR;
      end
      cmd_backlog.push_back(c);
    end
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || start || results_due.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [7:0] attr_plan [6];
    shadow_attr = ATTR_RESET;
    shadow_col  = '0;
    shadow_row  = '0;
    blank_grid();
    attr_plan = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    for (int p = 2; p < 6; p++) attr_plan[p] = 8'($urandom_range(0, 255));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    check_attr();

    // directed: reads, saturation, wrap, both scroll paths, clear
    queue_cmd(FUNC_READ,  8'h00, 8'h00, 8'h00, 11'd0);
    queue_cmd(FUNC_READ,  8'h00, 8'h00, 8'h00, 11'(CELLS - 1));
    queue_cmd(FUNC_READ,  8'h00, 8'h00, 8'h00, 11'(CELLS));
    queue_cmd(FUNC_READ,  8'hFF, 8'hFF, 8'hFF, 11'h7FF);
    queue_cmd(FUNC_PUT,   8'h41, 8'h00, 8'h00, 11'd0);
    queue_cmd(FUNC_PUT,   8'h00, 8'h00, 8'h00, 11'd0);
    queue_cmd(FUNC_PUT,   8'hFF, 8'hFF, 8'hFF, 11'h7FF);
    queue_cmd(FUNC_PUT,   NEWLINE_CODE, 8'h00, 8'h00, 11'd0);
    queue_cmd(FUNC_READ,  8'h00, 8'h00, 8'h00, 11'd2);
    queue_cmd(FUNC_SET,   8'h00, 8'hFF, 8'hFF, 11'd0);
    queue_cmd(FUNC_PUT,   8'h7E, 8'h00, 8'h00, 11'd0);
    queue_cmd(FUNC_READ,  8'h00, 8'h00, 8'h00, 11'(CELLS - COLUMNS - 1));
    queue_cmd(FUNC_SET,   8'h00, 8'h00, 8'(ROWS - 1), 11'd0);
    queue_cmd(FUNC_PUT,   NEWLINE_CODE, 8'h00, 8'h00, 11'd0);
    queue_cmd(FUNC_SET,   8'h00, 8'(COLUMNS), 8'(ROWS), 11'd0);
    queue_cmd(FUNC_SET,   8'h00, 8'(COLUMNS - 1), 8'h00, 11'd0);
    queue_cmd(FUNC_PUT,   8'h5A, 8'h00, 8'h00, 11'd0);
    queue_cmd(FUNC_READ,  8'h00, 8'h00, 8'h00, 11'(CELLS - 2 * COLUMNS - 1));
    queue_cmd(FUNC_CLEAR, 8'hFF, 8'hFF, 8'hFF, 11'h7FF);
    queue_cmd(FUNC_READ,  8'h00, 8'h00, 8'h00, 11'(CELLS - COLUMNS - 1));
    queue_cmd(FUNC_PUT,   8'h55, 8'h00, 8'h00, 11'd0);
    queue_cmd(FUNC_READ,  8'h00, 8'h00, 8'h00, 11'd0);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_attr(attr_plan[p]);
      idle_en = (p < 5);
      queue_random_cmds(PHASE_ITEMS);
      drain();
    end

    repeat (2100) @(negedge clk);
    $display("covered %0d requests over %0d attribute settings: %0d puts, %0d scrolls",
             n_accepted, n_attr_writes + 1, n_puts, n_scrolls);
    $display("  %0d clears, %0d cursor sets, %0d cell reads, %0d results checked",
             n_clears, n_sets, n_reads, n_checked);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("text_console_writer_tb OK");
    end else begin
      $display("%0d mismatches, %0d results still pending", mismatches, results_due.size());
      $display("text_console_writer_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_cell_ram.sv
sv/tcw_seq.sv
sv/text_console_writer.sv
tb/text_console_writer_tb.sv
